// ===== rtl/resistive_touch_sample_processor_core_defines.svh =====
// Assertion macros shared by the touch sample processor RTL
`ifndef RESISTIVE_TOUCH_SAMPLE_PROCESSOR_CORE_DEFINES_SVH
`define RESISTIVE_TOUCH_SAMPLE_PROCESSOR_CORE_DEFINES_SVH

// Property checked at every rising clock edge outside reset
`define RTSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define RTSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtsp_pkg.sv =====
// Types and constants of the touch sample processor
package rtsp_pkg;

    localparam int SAMPLE_W  = 12;
    // Widest running sum over the supported frame lengths (up to 64 samples)
    localparam int SUM_MAX_W = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] SAT_MAX          = 12'd4095;
    localparam logic [SAMPLE_W-1:0] PRESS_LOW_RESET  = 12'd100;
    localparam logic [SAMPLE_W-1:0] PRESS_HIGH_RESET = 12'd4000;
    localparam logic [SAMPLE_W-1:0] FLOOR_RESET      = 12'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 2'd2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_AVG_X,
        BK_AVG_Y,
        BK_MUL,
        BK_SAT,
        BK_DIV,
        BK_DONE
    } rtsp_state_t;

    typedef struct packed {
        logic                 is_err;
        logic                 short_frame;
        logic [SUM_MAX_W-1:0] x_sum;
        logic [SUM_MAX_W-1:0] y_sum;
        logic [SAMPLE_W-1:0]  z1;
        logic [SAMPLE_W-1:0]  z2;
    } rtsp_job_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] press_low;
        logic [SAMPLE_W-1:0] press_high;
        logic [SAMPLE_W-1:0] floor;
    } rtsp_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_avg;
        logic [SAMPLE_W-1:0] y_avg;
        logic [SAMPLE_W-1:0] z1_out;
        logic [SAMPLE_W-1:0] z2_out;
        logic [SAMPLE_W-1:0] pressure;
        logic                pressed;
        logic                status;
        logic                short_frame;
    } rtsp_result_t;

endpackage

// ===== rtl/resistive_touch_sample_processor_core.sv =====
// Coordinate transactions are accepted while the job queue has room and give no result.
// A frame-closing transaction gives its result after passing through the back end:
// three multiplies, then a 12-step divider, which zero or saturated pressure skips;
// a bus error goes straight to the result register.
// A two-entry job queue lets the front keep collecting while the back end divides.
// Synchronous reset clears sums, queue, sequencer and output valid; registers load defaults.
module resistive_touch_sample_processor_core #(
    parameter int SAMPLE_COUNT = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]   s_x_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]   s_y_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]   s_z1_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]   s_z2_sample,
    input  logic                            s_bus_error,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rtsp_pkg::SAMPLE_W-1:0]   m_x_avg,
    output logic [rtsp_pkg::SAMPLE_W-1:0]   m_y_avg,
    output logic [rtsp_pkg::SAMPLE_W-1:0]   m_z1_out,
    output logic [rtsp_pkg::SAMPLE_W-1:0]   m_z2_out,
    output logic [rtsp_pkg::SAMPLE_W-1:0]   m_pressure,
    output logic                            m_pressed,
    output logic                            m_status,
    output logic                            m_short_frame,
    input  logic                            cfg_wr_en,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]   cfg_wdata
);
    import rtsp_pkg::*;

    rtsp_cfg_t    cfg_reg;
    rtsp_job_t    push_job;
    rtsp_job_t    pop_job;
    rtsp_result_t res;
    logic         push_valid;
    logic         push_ready;
    logic         pop_valid;
    logic         pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_low  <= PRESS_LOW_RESET;
            cfg_reg.press_high <= PRESS_HIGH_RESET;
            cfg_reg.floor      <= FLOOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRESS_LOW:  cfg_reg.press_low  <= cfg_wdata;
                CFG_PRESS_HIGH: cfg_reg.press_high <= cfg_wdata;
                CFG_FLOOR:      cfg_reg.floor      <= cfg_wdata;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    rtsp_front #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_x_sample  (s_x_sample),
        .s_y_sample  (s_y_sample),
        .s_z1_sample (s_z1_sample),
        .s_z2_sample (s_z2_sample),
        .s_bus_error (s_bus_error),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    rtsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    rtsp_back #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .cfg       (cfg_reg),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_x_avg       = res.x_avg;
    assign m_y_avg       = res.y_avg;
    assign m_z1_out      = res.z1_out;
    assign m_z2_out      = res.z2_out;
    assign m_pressure    = res.pressure;
    assign m_pressed     = res.pressed;
    assign m_status      = res.status;
    assign m_short_frame = res.short_frame;

endmodule

// ===== rtl/rtsp_front.sv =====
// Front end: accepts samples, accumulates coordinates, issues frame jobs
module rtsp_front #(
    parameter int SAMPLE_COUNT = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [rtsp_pkg::SAMPLE_W-1:0] s_x_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0] s_y_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0] s_z1_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0] s_z2_sample,
    input  logic                        s_bus_error,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rtsp_pkg::rtsp_job_t         push_job
);
    import rtsp_pkg::*;

    `include "resistive_touch_sample_processor_core_defines.svh"

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_COUNT);
    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_COUNT);

    logic [SUM_W-1:0] x_sum_reg, x_sum_next;
    logic [SUM_W-1:0] y_sum_reg, y_sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             s_fire;
    logic             room;

    assign s_ready    = push_ready;
    assign s_fire     = s_valid && s_ready;
    assign push_valid = s_valid && (s_func || s_bus_error);
    assign room       = (cnt_reg < CNT_FULL);

    always_comb begin
        push_job.is_err      = s_bus_error;
        push_job.short_frame = s_bus_error ? 1'b0 : room;
        push_job.x_sum       = s_bus_error ? '0 : SUM_MAX_W'(x_sum_reg);
        push_job.y_sum       = s_bus_error ? '0 : SUM_MAX_W'(y_sum_reg);
        push_job.z1          = s_bus_error ? '0 : s_z1_sample;
        push_job.z2          = s_bus_error ? '0 : s_z2_sample;
    end

    always_comb begin
        x_sum_next = x_sum_reg;
        y_sum_next = y_sum_reg;
        cnt_next   = cnt_reg;
        if (s_fire) begin
            if (s_bus_error || s_func) begin
                // frame closed or aborted: start afresh
                x_sum_next = '0;
                y_sum_next = '0;
                cnt_next   = '0;
            end else if (room) begin
                x_sum_next = x_sum_reg + SUM_W'(s_x_sample);
                y_sum_next = y_sum_reg + SUM_W'(s_y_sample);
                cnt_next   = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_sum_reg <= '0;
            y_sum_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            x_sum_reg <= x_sum_next;
            y_sum_reg <= y_sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    `RTSP_ASSERT(a_cnt_bound, cnt_reg <= CNT_FULL, "sample count past frame length")
    `RTSP_ASSERT_NEXT(a_close_clears, s_fire && (s_func || s_bus_error), cnt_reg == '0,
                      "frame not cleared after close")

endmodule

// ===== rtl/rtsp_queue.sv =====
// Two-entry job queue between front and back end
module rtsp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rtsp_pkg::rtsp_job_t in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output rtsp_pkg::rtsp_job_t out_job
);
    import rtsp_pkg::*;

    `include "resistive_touch_sample_processor_core_defines.svh"

    rtsp_job_t  mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `RTSP_ASSERT(a_count_bound, count_reg != 2'd3, "queue count out of range")
    `RTSP_ASSERT(a_ptr_match, (count_reg == 2'd1) == (wptr_reg != rptr_reg),
                 "queue pointers disagree with count")

endmodule

// ===== rtl/rtsp_back.sv =====
// Back end: averaging, pressure division and result register
module rtsp_back #(
    parameter int SAMPLE_COUNT = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  rtsp_pkg::rtsp_job_t    job,
    input  rtsp_pkg::rtsp_cfg_t    cfg,
    output logic                   res_valid,
    input  logic                   res_ready,
    output rtsp_pkg::rtsp_result_t res
);
    import rtsp_pkg::*;

    `include "resistive_touch_sample_processor_core_defines.svh"

    localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLE_COUNT);
    // floor(s * RECIP >> K) == s / SAMPLE_COUNT for every s below 2**SUM_W
    localparam int K      = SUM_W + $clog2(SAMPLE_COUNT);
    localparam int RW     = K + 1;
    localparam int PROD_W = SUM_W + RW;
    localparam int NUM_W  = 2 * SAMPLE_W;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << K) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
    localparam logic [3:0] DIV_LAST = 4'(SAMPLE_W - 1);

    rtsp_state_t         state_reg, state_next;
    rtsp_job_t           job_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] xa_reg;
    logic [SAMPLE_W-1:0] ya_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                zero_reg;
    logic                sat_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [SAMPLE_W-1:0] q_reg;
    logic [3:0]          div_cnt_reg;
    rtsp_result_t        res_reg, res_next;
    logic                res_valid_reg;
    logic                load_out;

    logic [SAMPLE_W:0]   trial;
    logic                trial_ge;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] press;

    assign trial    = {rem_reg, lo_reg[SAMPLE_W-1]};
    assign trial_ge = (trial >= {1'b0, job_reg.z1});
    assign diff     = job_reg.z2 - job_reg.z1;
    assign press    = zero_reg ? '0 : (sat_reg ? SAT_MAX : q_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    state_next = job.is_err ? BK_DONE : BK_AVG_X;
                end
            end
            BK_AVG_X: state_next = BK_AVG_Y;
            BK_AVG_Y: state_next = BK_MUL;
            BK_MUL:   state_next = BK_SAT;
            BK_SAT: begin
                if (zero_reg || (num_reg >= {job_reg.z1, {SAMPLE_W{1'b0}}})) begin
                    state_next = BK_DONE;
                end else begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!res_valid_reg || res_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        job_ready = (state_reg == BK_IDLE);
        load_out  = (state_reg == BK_DONE) && (!res_valid_reg || res_ready);
    end

    always_comb begin
        if (job_reg.is_err) begin
            res_next        = '0;
            res_next.status = 1'b1;
        end else begin
            res_next.x_avg       = xa_reg;
            res_next.y_avg       = ya_reg;
            res_next.z1_out      = job_reg.z1;
            res_next.z2_out      = job_reg.z2;
            res_next.pressure    = press;
            res_next.pressed     = (press > cfg.press_low) && (press < cfg.press_high)
                                   && (job_reg.z1 > cfg.floor);
            res_next.status      = 1'b0;
            res_next.short_frame = job_reg.short_frame;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_reg <= job;
                end
            end
            BK_AVG_X: prod_reg <= job_reg.x_sum[SUM_W-1:0] * RECIP;
            BK_AVG_Y: begin
                xa_reg   <= prod_reg[K +: SAMPLE_W];
                prod_reg <= job_reg.y_sum[SUM_W-1:0] * RECIP;
            end
            BK_MUL: begin
                ya_reg   <= prod_reg[K +: SAMPLE_W];
                num_reg  <= xa_reg * diff;
                zero_reg <= (job_reg.z1 == '0) || (job_reg.z1 >= job_reg.z2);
            end
            BK_SAT: begin
                // below saturation the upper half is already smaller than Z1
                sat_reg     <= (num_reg >= {job_reg.z1, {SAMPLE_W{1'b0}}});
                rem_reg     <= num_reg[NUM_W-1:SAMPLE_W];
                lo_reg      <= num_reg[SAMPLE_W-1:0];
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            BK_DIV: begin
                rem_reg     <= trial_ge ? SAMPLE_W'(trial - {1'b0, job_reg.z1})
                                        : trial[SAMPLE_W-1:0];
                lo_reg      <= {lo_reg[SAMPLE_W-2:0], 1'b0};
                q_reg       <= {q_reg[SAMPLE_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            BK_DONE: begin
                if (job_reg.is_err) begin
                    zero_reg <= 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `RTSP_ASSERT_NEXT(a_load_valid, load_out, res_valid_reg, "loaded result not presented")
    `RTSP_ASSERT(a_div_needed, (state_reg != BK_DIV) || (!zero_reg && !sat_reg && !job_reg.is_err),
                 "divider running on a trivial frame")
    `RTSP_ASSERT(a_err_quiet, !(res_valid_reg && res_reg.status) ||
                 (!res_reg.pressed && (res_reg.pressure == '0)),
                 "error result carries pressure")

endmodule
